### hdl/ricc_pkg.sv
`timescale 1ns / 1ps

package ricc_pkg;

    localparam int unsigned MAX_IMAGE_BYTES = 8388608;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;
    localparam logic [23:0] HDR_LEN     = 24'd16;
    localparam logic [23:0] TRAINER_LEN = 24'd512;

    localparam logic [7:0] FLAG6_TRAINER = 8'h04;
    localparam logic [7:0] FLAG7_VER_MSK = 8'h0C;
    localparam logic [7:0] FLAG7_VER_TWO = 8'h08;
    localparam logic [7:0] NIBBLE_HI     = 8'hF0;

    // "N", "E", "S", EOF
    localparam logic [7:0] MAGIC [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_VER_TWO   = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_CRC_BAD   = 3'd4
    } t_status;

    typedef enum logic {
        REG_IMAGE_SIZE = 1'b0,
        REG_PASS_MODE  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_COPY   = 1'b0,
        MODE_VERIFY = 1'b1
    } t_mode;

    // reflected CRC-32, one byte, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/ricc_if.sv
`timescale 1ns / 1ps

interface ricc_byte_if import ricc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ricc_result_if import ricc_pkg::*; ();
    logic        valid;
    logic        ready;
    t_status     status;
    logic [31:0] image_crc;
    logic [21:0] prg_bytes;
    logic [20:0] chr_bytes;
    logic [7:0]  mapper;
    logic [7:0]  flags_six;
    logic [7:0]  flags_seven;

    modport source (output valid, output status, output image_crc, output prg_bytes,
                    output chr_bytes, output mapper, output flags_six, output flags_seven,
                    input ready);
    modport sink   (input valid, input status, input image_crc, input prg_bytes,
                    input chr_bytes, input mapper, input flags_six, input flags_seven,
                    output ready);
endinterface

### hdl/rom_image_header_crc_check.sv
`timescale 1ns / 1ps
// Pipeline: a byte passes through the input register, then the result register; the
// byte-wide CRC update and the header length compare sit between the two.
// Throughput: one byte per cycle while the result output is not held stalled.
// A result waiting at the output stalls the pipe only when the input register is full.
// Reset: synchronous, active low; copy pass armed, image_size 16, stored CRC zero.

module rom_image_header_crc_check import ricc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ricc_byte_if.sink   i_in,
    ricc_result_if.source o_res
);

    logic [23:0] r_image_size;
    t_mode       r_pass_mode;
    logic [23:0] r_pos;
    logic [31:0] r_crc;
    logic [31:0] r_stored_crc;
    logic [7:0]  r_hdr [4];
    logic        r_magic_ok;
    logic        r_pass_done;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic        r_out_valid;
    t_status     r_res_status;
    logic [31:0] r_res_crc;
    logic [21:0] r_res_prg;
    logic [20:0] r_res_chr;
    logic [7:0]  r_res_mapper;
    logic [7:0]  r_res_f6;
    logic [7:0]  r_res_f7;

    logic        advance;
    logic        fire;
    logic        cfg_wr;
    logic        pass_restart;

    logic [31:0] n_crc;
    logic [31:0] n_final;
    logic [7:0]  n_hdr [4];
    logic        n_magic_ok;
    logic [24:0] pos_inc;
    logic [21:0] prg_sz;
    logic [20:0] chr_sz;
    logic [23:0] need;
    logic [24:0] verify_len;
    t_status     hdr_st;
    logic        has_result;
    t_status     res_status;
    logic        res_details;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pass_restart = cfg_wr && (t_reg_idx'(paddr[2]) == REG_PASS_MODE);

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_IMAGE_SIZE: prdata = {8'd0, r_image_size};
            REG_PASS_MODE:  prdata = {31'd0, r_pass_mode};
            default:        prdata = '0;
        endcase
    end

    assign advance   = !r_out_valid || o_res.ready;
    assign fire      = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        n_crc      = crc_byte(r_crc, r_in_byte);
        n_final    = n_crc ^ CRC_ONES;
        pos_inc    = {1'b0, r_pos} + 25'd1;
        n_hdr      = r_hdr;
        n_magic_ok = r_magic_ok;
        if (r_pass_mode == MODE_COPY) begin
            if (r_pos < 24'd4) begin
                if (r_in_byte != MAGIC[r_pos[1:0]]) n_magic_ok = 1'b0;
            end else if (r_pos < 24'd8) begin
                n_hdr[r_pos[1:0]] = r_in_byte;
            end
        end

        prg_sz = {n_hdr[0], 14'd0};
        chr_sz = {n_hdr[1], 13'd0};
        need   = HDR_LEN + ((n_hdr[2] & FLAG6_TRAINER) != 8'd0 ? TRAINER_LEN : 24'd0)
               + {2'd0, prg_sz} + {3'd0, chr_sz};

        priority if (r_image_size < HDR_LEN ||
                     {1'b0, r_image_size} > 25'(MAX_IMAGE_BYTES)) hdr_st = ST_TOO_SHORT;
        else if (!n_magic_ok)                                 hdr_st = ST_BAD_HDR;
        else if ((n_hdr[3] & FLAG7_VER_MSK) == FLAG7_VER_TWO) hdr_st = ST_VER_TWO;
        else if (n_hdr[0] == 8'd0)                            hdr_st = ST_BAD_HDR;
        else if (r_image_size < need)                         hdr_st = ST_TOO_SHORT;
        else                                                  hdr_st = ST_OK;

        priority if (r_image_size < HDR_LEN)                        verify_len = {1'b0, HDR_LEN};
        else if ({1'b0, r_image_size} > 25'(MAX_IMAGE_BYTES))       verify_len = 25'(MAX_IMAGE_BYTES);
        else                                                        verify_len = {1'b0, r_image_size};

        has_result  = 1'b0;
        res_status  = ST_OK;
        res_details = 1'b1;
        if (!r_pass_done) begin
            if (r_pass_mode == MODE_COPY) begin
                priority if (r_pos == 24'd7 && hdr_st != ST_OK) begin
                    has_result  = 1'b1;
                    res_status  = hdr_st;
                    res_details = 1'b0;
                end else if (r_pos >= 24'd7 && pos_inc == {1'b0, r_image_size}) begin
                    has_result = 1'b1;
                end else begin
                    has_result = 1'b0;
                end
            end else if (pos_inc == verify_len) begin
                has_result = 1'b1;
                res_status = (n_final == r_stored_crc) ? ST_OK : ST_CRC_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= HDR_LEN;
            r_pass_mode  <= MODE_COPY;
            r_pos        <= '0;
            r_crc        <= CRC_ONES;
            r_stored_crc <= '0;
            r_hdr        <= '{default: 8'd0};
            r_magic_ok   <= 1'b1;
            r_pass_done  <= 1'b0;
        end else begin
            if (fire && !r_pass_done) begin
                r_crc      <= n_crc;
                r_pos      <= pos_inc[23:0];
                r_hdr      <= n_hdr;
                r_magic_ok <= n_magic_ok;
                if (has_result) r_pass_done <= 1'b1;
                if (has_result && r_pass_mode == MODE_COPY && res_details) begin
                    r_stored_crc <= n_final;
                end
            end
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[2]))
                    REG_IMAGE_SIZE: r_image_size <= pwdata[23:0];
                    REG_PASS_MODE: begin
                        r_pass_mode <= t_mode'(pwdata[0]);
                        r_pos       <= '0;
                        r_crc       <= CRC_ONES;
                        r_magic_ok  <= 1'b1;
                        r_pass_done <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) r_in_valid <= 1'b1;
            else if (advance)             r_in_valid <= 1'b0;
            if (advance) r_out_valid <= fire && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in_byte <= i_in.data_byte;
        if (fire && has_result) begin
            r_res_status <= res_status;
            r_res_crc    <= res_details ? n_final : 32'd0;
            r_res_prg    <= res_details ? prg_sz : 22'd0;
            r_res_chr    <= res_details ? chr_sz : 21'd0;
            r_res_mapper <= res_details ? ((n_hdr[2] >> 4) | (n_hdr[3] & NIBBLE_HI)) : 8'd0;
            r_res_f6     <= n_hdr[2];
            r_res_f7     <= n_hdr[3];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_res_status;
    assign o_res.image_crc   = r_res_crc;
    assign o_res.prg_bytes   = r_res_prg;
    assign o_res.chr_bytes   = r_res_chr;
    assign o_res.mapper      = r_res_mapper;
    assign o_res.flags_six   = r_res_f6;
    assign o_res.flags_seven = r_res_f7;

    // a finished pass reopens only through a pass_mode write
    a_done_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_pass_done) |-> $past(pass_restart))
        else $error("pass reopened without pass_mode write");

    // header failures carry no CRC or size details
    a_fail_no_detail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res_status == ST_BAD_HDR || r_res_status == ST_VER_TWO))
        |-> (r_res_crc == 32'd0 && r_res_prg == 22'd0 && r_res_mapper == 8'd0))
        else $error("header failure result carries details");

    // byte position moves only with a processed byte or a pass restart
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fire && !pass_restart) |=> $stable(r_pos))
        else $error("byte position moved without a byte");

endmodule
